// File: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes of the double-ended queue: request and result
// payloads, the stored record, operation and status codes, control states.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  // Default capacity in records
  localparam int unsigned DEQ_DEPTH = 16;

  // Operation codes carried in the request
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_LIST       = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic        [2:0]  op;
    logic signed [31:0] number;
    logic        [63:0] text_bytes_low;
    logic        [63:0] text_bytes_mid;
    logic        [31:0] text_bytes_high;
  } deq_req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] entry_number;
    logic        [63:0] entry_text_low;
    logic        [63:0] entry_text_mid;
    logic        [31:0] entry_text_high;
    logic               last;
  } deq_rsp_t;

  // One record as held in the ring store
  typedef struct packed {
    logic signed [31:0] number;
    logic        [63:0] text_low;
    logic        [63:0] text_mid;
    logic        [31:0] text_high;
  } deq_rec_t;

  typedef enum logic {
    DEQ_IDLE,
    DEQ_LIST
  } deq_state_e;

endpackage

`default_nettype wire

// File: rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data that holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Queue controller: front pointer and fill count, push and pop decode,
// ring store addressing and the list walk over the stored records.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl import deq_pkg::*; #(
  parameter int unsigned DEPTH = DEQ_DEPTH,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire deq_req_t      in_req_i,
  output logic               in_stall_o,
  input  wire logic          res_ready_i,
  output logic               res_valid_o,
  output deq_rsp_t           res_o,
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output deq_rec_t           ram_wdata_o,
  output logic               ram_re_o,
  output logic [AW-1:0]      ram_raddr_o,
  input  wire deq_rec_t      ram_rdata_i,
  output logic               busy_o,
  output logic [CW-1:0]      count_o
);

  localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_W    = (AW + 1)'(DEPTH);

  deq_state_e    state_q, state_d;
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] idx_q, idx_d;

  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic [AW:0]   back_sum;
  logic [AW-1:0] back_slot;
  logic [AW-1:0] prev_front;
  logic [AW-1:0] next_front;
  logic [AW-1:0] next_ptr;
  logic          list_last;

  assign in_stall_o = (state_q != DEQ_IDLE) || !res_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_full    = (count_q == FULL_COUNT);
  assign is_empty   = (count_q == '0);

  // Back slot = (front + count) mod DEPTH; the sum stays below twice DEPTH
  assign back_sum   = (AW + 1)'(front_q) + (AW + 1)'(count_q);
  assign back_slot  = (back_sum >= DEPTH_W) ? AW'(back_sum - DEPTH_W) : AW'(back_sum);
  assign prev_front = (front_q == '0) ? LAST_SLOT : front_q - 1'b1;
  assign next_front = (front_q == LAST_SLOT) ? '0 : front_q + 1'b1;
  assign next_ptr   = (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
  assign list_last  = ((idx_q + CW'(1)) == count_q);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = back_slot;
    ram_wdata_o = '{number:    in_req_i.number,
                    text_low:  in_req_i.text_bytes_low,
                    text_mid:  in_req_i.text_bytes_mid,
                    text_high: in_req_i.text_bytes_high};
    ram_re_o    = 1'b0;
    ram_raddr_o = front_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.last  = 1'b1;

    case (state_q)
      DEQ_IDLE: begin
        if (accept) begin
          case (in_req_i.op)
            OP_PUSH_FRONT: begin
              res_valid_o = 1'b1;
              if (is_full) begin
                res_o.status = STATUS_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = prev_front;
                front_d     = prev_front;
                count_d     = count_q + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              res_valid_o = 1'b1;
              if (is_full) begin
                res_o.status = STATUS_FULL;
              end else begin
                ram_we_o = 1'b1;
                count_d  = count_q + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              res_valid_o = 1'b1;
              if (is_empty) begin
                res_o.status = STATUS_EMPTY;
              end else begin
                front_d = next_front;
                count_d = count_q - 1'b1;
              end
            end
            OP_POP_BACK: begin
              res_valid_o = 1'b1;
              if (is_empty) begin
                res_o.status = STATUS_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            OP_LIST: begin
              if (is_empty) begin
                res_valid_o  = 1'b1;
                res_o.status = STATUS_EMPTY;
              end else begin
                // Fetch the front record; it shows on the read port next cycle
                ram_re_o = 1'b1;
                ptr_d    = next_front;
                idx_d    = '0;
                state_d  = DEQ_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      DEQ_LIST: begin
        if (res_ready_i) begin
          res_valid_o           = 1'b1;
          res_o.status          = STATUS_OK;
          res_o.entry_number    = ram_rdata_i.number;
          res_o.entry_text_low  = ram_rdata_i.text_low;
          res_o.entry_text_mid  = ram_rdata_i.text_mid;
          res_o.entry_text_high = ram_rdata_i.text_high;
          res_o.last            = list_last;
          if (list_last) begin
            state_d = DEQ_IDLE;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = ptr_q;
            ptr_d       = next_ptr;
            idx_d       = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = DEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DEQ_IDLE;
      front_q <= '0;
      count_q <= '0;
      ptr_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      idx_q   <= idx_d;
    end
  end

  assign busy_o  = (state_q != DEQ_IDLE);
  assign count_o = count_q;

endmodule

`default_nettype wire

// File: rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of records (signed number plus 20-byte text)
// held in a ring store, with push/pop at both ends and an ordered listing.
// ----------------------------------------------------------------------------
// Each request carries an op: push front, push back, pop front, pop back or
// list. A push or pop answers with one result (status ok, empty or full, data
// fields zero, last set); requests of this kind follow back to back as long
// as the result register drains. A push into a full queue drops the record
// and reports full; a pop from an empty queue reports empty. A list walks the
// records from front to back through the registered read port of the ring
// store: it first fetches the front record, then gives one result per cycle
// while the result register drains, and the input stays stalled until the
// record marked last has been issued. A list of an empty queue gives a single
// empty result. Unused op codes are taken and give no result. The store holds
// DEPTH records and needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue import deq_pkg::*; #(
  parameter int unsigned DEPTH = DEQ_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire deq_req_t in_req_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output deq_rsp_t      out_rsp_o,
  input  wire logic     out_stall_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic          res_ready;
  logic          res_valid;
  deq_rsp_t      res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  deq_rec_t      ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  deq_rec_t      ram_rdata;
  logic          busy;
  logic [CW-1:0] count;

  logic          out_valid_q, out_valid_d;
  deq_rsp_t      out_rsp_q;

  // Controller: pointers, decode and list walk
  deq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .busy_o      (busy),
    .count_o     (count)
  );

  // Ring store of records
  deq_ram #(
    .WIDTH ($bits(deq_rec_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register: free when empty or being taken this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load a new result only into a free register; hold it otherwise
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef NO_ASSERTIONS
  // Fill count never exceeds capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(DEPTH))
    else $error("fill count above capacity");

  // No request is taken while a list walk is running
  a_stall_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o)
    else $error("request accepted during list walk");

  // A push into a full queue leaves the fill count alone
  a_full_push_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && count == CW'(DEPTH) &&
     (in_req_i.op == OP_PUSH_FRONT || in_req_i.op == OP_PUSH_BACK))
    |=> $stable(count))
    else $error("push into full queue changed fill count");

  // A list walk always ends with a result marked last
  a_list_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(busy) && !busy) |-> (out_valid_o && out_rsp_o.last))
    else $error("list walk ended without last result");
`endif

endmodule

`default_nettype wire
